// ----- hdl/bpj_pkg.sv -----
package bpj_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int FIELD_WIDTH     = 16;
	localparam int CFG_DATA_WIDTH  = 64;
	localparam int FRAC_SHIFT      = 14;
	localparam int TRANS_SHIFT     = 22;

	localparam logic [15:0] DEPTH_MIN_RAW = 16'd41;
	localparam logic [15:0] DEPTH_MAX_RAW = 16'd40960;

	localparam logic [15:0] FOCAL_X_RST  = 16'd8192;
	localparam logic [15:0] FOCAL_Y_RST  = 16'd8192;
	localparam logic [15:0] CENTER_X_RST = 16'd5120;
	localparam logic [15:0] CENTER_Y_RST = 16'd3840;
	localparam logic [63:0] POSE_0_RST   = 64'h0000_0000_0000_4000;
	localparam logic [63:0] POSE_1_RST   = 64'h0000_0000_4000_0000;
	localparam logic [63:0] POSE_2_RST   = 64'h0000_4000_0000_0000;

	typedef enum logic [2:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_POSE_0   = 3'd4,
		REG_POSE_1   = 3'd5,
		REG_POSE_2   = 3'd6,
		REG_FRAME_ID = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        keep;
		logic [15:0] depth;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        frame_end;
	} side_t;

	function automatic logic mod3_zero(input logic [15:0] v);
		logic [4:0] s;
		logic       hit;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		hit = 1'b0;
		for (int k = 0; k <= 8; k++) begin
			if (s == 5'(3 * k)) hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ----- hdl/bpj_div.sv -----
module bpj_div #(
	parameter int NW = 36,
	parameter int SW = 42
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [NW-1:0]        mag_x,
	input  logic [NW-1:0]        mag_y,
	input  logic                 neg_x,
	input  logic                 neg_y,
	input  logic [15:0]          div_x,
	input  logic [15:0]          div_y,
	input  logic [SW-1:0]        in_side,
	output logic                 out_vld,
	output logic signed [NW:0]   quo_x,
	output logic signed [NW:0]   quo_y,
	output logic [SW-1:0]        out_side
);
	import bpj_pkg::*;

	logic [NW:0]     vld_s;
	logic [15:0]     rx_s  [NW+1];
	logic [15:0]     ry_s  [NW+1];
	logic [NW-1:0]   wx_s  [NW+1];
	logic [NW-1:0]   wy_s  [NW+1];
	logic [NW:0]     nx_s;
	logic [NW:0]     ny_s;
	logic [SW-1:0]   sd_s  [NW+1];

	assign vld_s[0] = in_vld;
	assign rx_s[0]  = '0;
	assign ry_s[0]  = '0;
	assign wx_s[0]  = mag_x;
	assign wy_s[0]  = mag_y;
	assign nx_s[0]  = neg_x;
	assign ny_s[0]  = neg_y;
	assign sd_s[0]  = in_side;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [16:0] tx, ty;
		logic        bx, by;
		always_comb begin
			tx = {rx_s[i], wx_s[i][NW-1]};
			ty = {ry_s[i], wy_s[i][NW-1]};
			bx = (tx >= {1'b0, div_x});
			by = (ty >= {1'b0, div_y});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[i+1] <= bx ? 16'(tx - {1'b0, div_x}) : tx[15:0];
				ry_s[i+1] <= by ? 16'(ty - {1'b0, div_y}) : ty[15:0];
				wx_s[i+1] <= {wx_s[i][NW-2:0], bx};
				wy_s[i+1] <= {wy_s[i][NW-2:0], by};
				nx_s[i+1] <= nx_s[i];
				ny_s[i+1] <= ny_s[i];
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_x    <= nx_s[NW] ? -$signed({1'b0, wx_s[NW]}) : $signed({1'b0, wx_s[NW]});
			quo_y    <= ny_s[NW] ? -$signed({1'b0, wy_s[NW]}) : $signed({1'b0, wy_s[NW]});
			out_side <= sd_s[NW];
		end
	end

endmodule

// ----- hdl/bpj_axis.sv -----
module bpj_axis #(
	parameter int QW = 37
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [QW-1:0] xc,
	input  logic signed [QW-1:0] yc,
	input  logic signed [20:0]  zc,
	input  logic [63:0]         pose,
	output logic signed [31:0]  world
);
	import bpj_pkg::*;

	localparam int PW = QW + 16;

	logic signed [PW-1:0] p0_s1, p1_s1;
	logic signed [36:0]   p2_s1;
	logic signed [15:0]   t_s1;
	logic signed [63:0]   acc_s2;
	logic signed [63:0]   biased;
	logic signed [63:0]   shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= $signed(pose[15:0]) * xc;
			p1_s1 <= $signed(pose[31:16]) * yc;
			p2_s1 <= $signed(pose[47:32]) * zc;
			t_s1  <= $signed(pose[63:48]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= 64'(p0_s1) + 64'(p1_s1) + 64'(p2_s1) + (64'(t_s1) <<< TRANS_SHIFT);
		end
	end

	always_comb begin
		biased  = acc_s2 + (acc_s2[63] ? 64'sd16383 : 64'sd0);
		shifted = biased >>> FRAC_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (shifted > 64'sd2147483647) begin
				world <= 32'sh7FFF_FFFF;
			end else if (shifted < -64'sd2147483648) begin
				world <= 32'sh8000_0000;
			end else begin
				world <= shifted[31:0];
			end
		end
	end

endmodule

// ----- hdl/depth_pixel_backprojection_top.sv -----
// Depth pixel back-projection to world points.
// Input channel: one RGB-D pixel per transfer (in_valid/in_stall) with row,
// column, Q4.12 depth, colour bytes and an end-of-frame mark.
// Output channel: one result per input pixel (out_valid/out_stall). A pixel on
// the 3x3 grid with depth 41..40960 raw gives point_valid=1 and its world
// position in Q16.16; any other pixel gives an all-zero result with
// frame_end still copied.
// Configuration: cfg_write/cfg_index/cfg_data, write only, while idle.
// Throughput: one pixel per cycle while the output is not stalled. The
// one-bit-a-stage restoring divider for x and y, NW = max(W+4,16)+20 bits wide
// with W = COORD_WIDTH, makes up most of the pipeline.
// Stall: the whole pipeline holds while a result waits at the output;
// in_stall then rises in the same cycle, nothing is dropped or repeated.
// Reset: pipeline empties, registers return to identity pose, 320/240 center,
// 512 pixel focal lengths, frame id 0.
module depth_pixel_backprojection_top #(
	parameter int COORD_WIDTH = bpj_pkg::COORD_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [2:0]                   cfg_index,
	input  logic [bpj_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [COORD_WIDTH-1:0]       pixel_row,
	input  logic [COORD_WIDTH-1:0]       pixel_col,
	input  logic [15:0]                  depth_raw,
	input  logic [7:0]                   in_blue,
	input  logic [7:0]                   in_green,
	input  logic [7:0]                   in_red,
	input  logic                         frame_end_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         point_valid,
	output logic signed [31:0]           world_x,
	output logic signed [31:0]           world_y,
	output logic signed [31:0]           world_z,
	output logic [7:0]                   out_blue,
	output logic [7:0]                   out_green,
	output logic [7:0]                   out_red,
	output logic [31:0]                  point_frame_id,
	output logic                         frame_end
);
	import bpj_pkg::*;

	localparam int CSW = COORD_WIDTH + 4;
	localparam int DXW = ((CSW > FIELD_WIDTH) ? CSW : FIELD_WIDTH) + 1;
	localparam int MW  = DXW - 1;
	localparam int NW  = MW + 20;
	localparam int QW  = NW + 1;
	localparam int SW  = $bits(side_t);

	logic [15:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [63:0] pose_0_q, pose_1_q, pose_2_q;
	logic [31:0] frame_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
			pose_0_q   <= POSE_0_RST;
			pose_1_q   <= POSE_1_RST;
			pose_2_q   <= POSE_2_RST;
			frame_id_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FOCAL_X:  focal_x_q  <= cfg_data[15:0];
				REG_FOCAL_Y:  focal_y_q  <= cfg_data[15:0];
				REG_CENTER_X: center_x_q <= cfg_data[15:0];
				REG_CENTER_Y: center_y_q <= cfg_data[15:0];
				REG_POSE_0:   pose_0_q   <= cfg_data;
				REG_POSE_1:   pose_1_q   <= cfg_data;
				REG_POSE_2:   pose_2_q   <= cfg_data;
				REG_FRAME_ID: frame_id_q <= cfg_data[31:0];
				default:      frame_id_q <= frame_id_q;
			endcase
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [15:0] div_x, div_y;
	assign div_x = (focal_x_q == '0) ? 16'd1 : focal_x_q;
	assign div_y = (focal_y_q == '0) ? 16'd1 : focal_y_q;

	logic keep_in;
	assign keep_in = mod3_zero(16'(pixel_row)) && mod3_zero(16'(pixel_col))
		&& (depth_raw >= DEPTH_MIN_RAW) && (depth_raw <= DEPTH_MAX_RAW);

	logic                  vld_s1;
	side_t                 side_s1;
	logic signed [DXW-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.keep      <= keep_in;
			side_s1.depth     <= depth_raw;
			side_s1.blue      <= in_blue;
			side_s1.green     <= in_green;
			side_s1.red       <= in_red;
			side_s1.frame_end <= frame_end_in;
			dx_s1 <= $signed(DXW'({pixel_col, 4'b0000})) - $signed(DXW'(center_x_q));
			dy_s1 <= $signed(DXW'({pixel_row, 4'b0000})) - $signed(DXW'(center_y_q));
		end
	end

	logic [MW-1:0] ax, ay;
	always_comb begin
		ax = dx_s1[DXW-1] ? MW'(-dx_s1) : MW'(dx_s1);
		ay = dy_s1[DXW-1] ? MW'(-dy_s1) : MW'(dy_s1);
	end

	logic            vld_s2;
	side_t           side_s2;
	logic [MW+15:0]  px_s2, py_s2;
	logic            nx_s2, ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			px_s2   <= ax * side_s1.depth;
			py_s2   <= ay * side_s1.depth;
			nx_s2   <= dx_s1[DXW-1];
			ny_s2   <= dy_s1[DXW-1];
		end
	end

	logic               dvld;
	logic signed [NW:0] qx, qy;
	logic [SW-1:0]      dside_raw;
	side_t              dside;
	assign dside = side_t'(dside_raw);

	bpj_div #(.NW(NW), .SW(SW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.mag_x    ({px_s2, 4'b0000}),
		.mag_y    ({py_s2, 4'b0000}),
		.neg_x    (nx_s2),
		.neg_y    (ny_s2),
		.div_x    (div_x),
		.div_y    (div_y),
		.in_side  (side_s2),
		.out_vld  (dvld),
		.quo_x    (qx),
		.quo_y    (qy),
		.out_side (dside_raw)
	);

	logic signed [20:0] zc;
	assign zc = $signed({1'b0, dside.depth, 4'b0000});

	logic signed [31:0] world_x_r, world_y_r, world_z_r;

	bpj_axis #(.QW(QW)) u_ax_x (
		.clk(clk), .en(en), .xc(qx), .yc(qy), .zc(zc), .pose(pose_0_q), .world(world_x_r)
	);
	bpj_axis #(.QW(QW)) u_ax_y (
		.clk(clk), .en(en), .xc(qx), .yc(qy), .zc(zc), .pose(pose_1_q), .world(world_y_r)
	);
	bpj_axis #(.QW(QW)) u_ax_z (
		.clk(clk), .en(en), .xc(qx), .yc(qy), .zc(zc), .pose(pose_2_q), .world(world_z_r)
	);

	logic  vld_s3, vld_s4;
	side_t side_s3, side_s4, side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s3    <= dvld;
			vld_s4    <= vld_s3;
			out_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= dside;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	always_comb begin
		point_valid    = side_s5.keep;
		world_x        = side_s5.keep ? world_x_r : '0;
		world_y        = side_s5.keep ? world_y_r : '0;
		world_z        = side_s5.keep ? world_z_r : '0;
		out_blue       = side_s5.keep ? side_s5.blue : '0;
		out_green      = side_s5.keep ? side_s5.green : '0;
		out_red        = side_s5.keep ? side_s5.red : '0;
		point_frame_id = side_s5.keep ? frame_id_q : '0;
		frame_end      = side_s5.frame_end;
	end

`ifndef SYNTHESIS
	a_stall_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow the output stall");

	a_frame_id_on_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && point_valid |-> point_frame_id == frame_id_q)
		else $error("kept point carries wrong frame id");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> world_z == '0 && out_red == '0)
		else $error("dropped pixel has nonzero payload");
`endif

endmodule
